FILE: src/phr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types, constants, and the command and status structs of the heart-rate detector.
// ----------------------------------------------------------------------------
package phr_pkg;

    localparam int WINDOW_LEN     = 16;
    localparam int AVERAGE_TAPS   = 5;
    localparam int INTERVAL_DEPTH = 8;
    localparam int WIN_W = $clog2(WINDOW_LEN);
    localparam int AVG_W = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
    localparam int INT_W = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;

    // Reciprocals for exact truncating division of magnitudes below 2^17.
    localparam int          RECIP_SHIFT = 22;
    localparam logic [22:0] AVG_RECIP   =
        23'(((1 << RECIP_SHIFT) + AVERAGE_TAPS - 1) / AVERAGE_TAPS);
    localparam logic [22:0] FIFTH_RECIP = 23'(((1 << RECIP_SHIFT) + 4) / 5);

    localparam logic [1:0] REG_ALPHA    = 2'd0;
    localparam logic [1:0] REG_AMBIENT  = 2'd1;
    localparam logic [1:0] REG_MIN_BEAT = 2'd2;

    localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
    localparam logic [7:0]  BPM_LOW       = 8'd40;
    localparam logic [7:0]  BPM_HIGH      = 8'd180;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA,
        ST_AVG,
        ST_SCAN,
        ST_THR,
        ST_PEAK,
        ST_SUM,
        ST_DIV,
        ST_RATE,
        ST_OUT
    } phr_state_t;

    typedef struct packed {
        logic load;
        logic ema;
        logic avg;
        logic scan_start;
        logic thr;
        logic peak;
        logic sum_start;
        logic div_start;
        logic rate;
        logic emit;
    } phr_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic peak_hit;
        logic sum_done;
        logic div_done;
    } phr_status_t;

endpackage
`default_nettype wire

FILE: src/phr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phr_divider
// Restoring divider, one quotient bit per cycle, 35-bit dividend.
// ----------------------------------------------------------------------------
module phr_divider import phr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [34:0] dividend,
    input  wire logic [34:0] divisor,
    output logic             done,
    output logic [34:0]      quotient
);
    logic [34:0] rem_reg, rem_next, quo_reg, quo_next, den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [35:0] trial;

    always_comb begin
        rem_next = rem_reg; quo_next = quo_reg; den_next = den_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        trial = {rem_reg, quo_reg[34]};
        done = 1'b0;
        if (start) begin
            rem_next = '0; quo_next = dividend; den_next = divisor;
            cnt_next = 6'd35; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done = 1'b1;
            end else begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 35'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[33:0], 1'b1};
                end else begin
                    rem_next = trial[34:0];
                    quo_next = {quo_reg[33:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: src/phr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phr_datapath
// Filters, window scan, threshold, peak test, interval averaging and rate.
// ----------------------------------------------------------------------------
module phr_datapath import phr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire phr_cmd_t           cmd,
    output phr_status_t             status,
    input  wire logic [8:0]         alpha_q8,
    input  wire logic [11:0]        ambient_baseline,
    input  wire logic [15:0]        min_beat_interval_ms,
    input  wire logic [11:0]        adc_sample,
    input  wire logic [31:0]        timestamp_ms,
    input  wire logic               finger_present,
    output logic                    finger,
    output logic signed [12:0]      filtered_value,
    output logic signed [12:0]      threshold_value,
    output logic                    peak_found,
    output logic [7:0]              beats_per_minute,
    output logic                    rate_valid
);
    logic signed [12:0] raw_reg;
    logic [31:0]        ts_reg;
    logic               finger_reg;
    logic signed [20:0] ema_reg, thr_acc_reg;
    logic signed [12:0] avg_ring_reg [AVERAGE_TAPS];
    logic [AVG_W-1:0]   avg_slot_reg;
    logic signed [12:0] win_ring_reg [WINDOW_LEN];
    logic [WIN_W-1:0]   win_slot_reg;
    logic [WIN_W:0]     scan_reg;
    logic               scanning_reg;
    logic signed [12:0] mn_reg, mx_reg, cur_reg, prev_reg;
    logic [31:0]        last_peak_reg;
    logic [31:0]        int_ring_reg [INTERVAL_DEPTH];
    logic [INT_W-1:0]   int_slot_reg;
    logic [INT_W:0]     sidx_reg;
    logic               summing_reg;
    logic [34:0]        sum_reg;
    logic [INT_W:0]     count_reg;
    logic [7:0]         rate_reg;
    logic               valid_reg, peak_reg;
    logic signed [12:0] thr_out_reg;
    logic signed [12:0] filt_out_reg;
    logic               peak_out_reg;
    logic [7:0]         rate_out_reg;
    logic               valid_out_reg;

    logic [8:0]         alpha_c;
    logic               div_done;
    logic [34:0]        quotient, dividend, divisor;

    assign alpha_c = (alpha_q8 == 9'd0) ? 9'd1 : (alpha_q8 > 9'd256 ? 9'd256 : alpha_q8);

    // acc' = floor((a*x*256 + (256-a)*acc) / 256) = a*x + floor((256-a)*acc/256)
    function automatic logic signed [20:0] ema_step(input logic [8:0] a,
                                                    input logic signed [20:0] acc,
                                                    input logic signed [12:0] x);
        logic signed [31:0] prod;
        logic signed [31:0] ax;
        prod = $signed({1'b0, 9'(9'd256 - a)}) * acc;
        ax   = $signed({1'b0, a}) * x;
        return 21'(ax + (prod >>> 8));
    endfunction

    function automatic logic signed [12:0] q8_int(input logic signed [20:0] acc);
        logic signed [20:0] t;
        t = acc + (acc[20] ? 21'sd255 : 21'sd0);
        return 13'(t >>> 8);
    endfunction

    function automatic logic [12:0] recip_div(input logic [16:0] x,
                                              input logic [22:0] r);
        logic [39:0] p;
        p = 40'(x) * 40'(r);
        return 13'(p >> RECIP_SHIFT);
    endfunction

    // Sum of the average ring with the entry being written this cycle already in
    // place, truncated toward zero division by the tap count.
    logic signed [16:0] avg_sum;
    logic signed [16:0] avg_abs;
    logic signed [12:0] avg_q;
    always_comb begin
        avg_sum = '0;
        for (int i = 0; i < AVERAGE_TAPS; i++)
            avg_sum = avg_sum + 17'((AVG_W'(i) == avg_slot_reg) ? q8_int(ema_reg)
                                                               : avg_ring_reg[i]);
        avg_abs = avg_sum[16] ? -avg_sum : avg_sum;
        avg_q = avg_sum[16] ? -recip_div($unsigned(avg_abs), AVG_RECIP)
                            : recip_div($unsigned(avg_abs), AVG_RECIP);
    end

    logic signed [15:0] nt_num;
    logic signed [15:0] nt_abs;
    logic signed [12:0] nt;
    always_comb begin
        nt_num = 16'sd5 * 16'(mn_reg) + 16'sd3 * (16'(mx_reg) - 16'(mn_reg));
        nt_abs = nt_num[15] ? -nt_num : nt_num;
        nt = nt_num[15] ? -recip_div({1'b0, $unsigned(nt_abs)}, FIFTH_RECIP)
                        : recip_div({1'b0, $unsigned(nt_abs)}, FIFTH_RECIP);
    end

    logic [31:0] interval;
    assign interval = ts_reg - last_peak_reg;
    assign status.peak_hit = (prev_reg > q8_int(thr_acc_reg)) && (cur_reg < prev_reg)
                             && (interval >= {16'd0, min_beat_interval_ms});
    assign status.scan_done = !scanning_reg && !cmd.scan_start;
    assign status.sum_done  = !summing_reg && !cmd.sum_start;
    assign status.div_done  = div_done;

    // The rate pass divides the constant by the mean that the first pass left.
    assign dividend = cmd.rate ? {19'd0, BPM_NUMERATOR} : sum_reg;
    assign divisor  = cmd.rate ? quotient : {{(35-INT_W-1){1'b0}}, count_reg};

    phr_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(dividend), .divisor(divisor), .done(div_done), .quotient(quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_reg <= '0; thr_acc_reg <= '0; avg_slot_reg <= '0; win_slot_reg <= '0;
            prev_reg <= '0; last_peak_reg <= '0; int_slot_reg <= '0;
            rate_reg <= '0; valid_reg <= 1'b0; peak_reg <= 1'b0;
            scanning_reg <= 1'b0; summing_reg <= 1'b0;
            thr_out_reg <= '0; finger_reg <= 1'b0;
            filt_out_reg <= '0; peak_out_reg <= 1'b0;
            rate_out_reg <= '0; valid_out_reg <= 1'b0;
            for (int i = 0; i < AVERAGE_TAPS; i++) avg_ring_reg[i] <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) win_ring_reg[i] <= '0;
            for (int i = 0; i < INTERVAL_DEPTH; i++) int_ring_reg[i] <= '0;
        end else begin
            if (cmd.load) begin
                raw_reg    <= 13'($signed({1'b0, adc_sample}) - $signed({1'b0, ambient_baseline}));
                ts_reg     <= timestamp_ms;
                finger_reg <= finger_present;
                peak_reg   <= 1'b0;
            end
            if (cmd.ema) ema_reg <= ema_step(alpha_c, ema_reg, raw_reg);
            if (cmd.avg) begin
                avg_ring_reg[avg_slot_reg] <= q8_int(ema_reg);
                avg_slot_reg <= (avg_slot_reg == AVG_W'(AVERAGE_TAPS - 1)) ? '0
                                : AVG_W'(avg_slot_reg + AVG_W'(1));
            end
            if (cmd.scan_start) begin
                cur_reg <= avg_q;
                win_ring_reg[win_slot_reg] <= avg_q;
                win_slot_reg <= (win_slot_reg == WIN_W'(WINDOW_LEN - 1)) ? '0
                                : WIN_W'(win_slot_reg + WIN_W'(1));
                mn_reg <= 13'sd4095; mx_reg <= -13'sd4096;
                scan_reg <= '0;
                scanning_reg <= 1'b1;
            end else if (scanning_reg) begin
                if (win_ring_reg[scan_reg[WIN_W-1:0]] < mn_reg)
                    mn_reg <= win_ring_reg[scan_reg[WIN_W-1:0]];
                if (win_ring_reg[scan_reg[WIN_W-1:0]] > mx_reg)
                    mx_reg <= win_ring_reg[scan_reg[WIN_W-1:0]];
                if (scan_reg == (WIN_W+1)'(WINDOW_LEN - 1)) scanning_reg <= 1'b0;
                scan_reg <= scan_reg + (WIN_W+1)'(1);
            end
            if (cmd.thr) thr_acc_reg <= ema_step(alpha_c, thr_acc_reg, nt);
            if (cmd.peak) begin
                if (status.peak_hit) begin
                    peak_reg <= 1'b1;
                    last_peak_reg <= ts_reg;
                    int_ring_reg[int_slot_reg] <= interval;
                    int_slot_reg <= (int_slot_reg == INT_W'(INTERVAL_DEPTH - 1)) ? '0
                                    : INT_W'(int_slot_reg + INT_W'(1));
                end
                prev_reg <= cur_reg;
            end
            if (cmd.sum_start) begin
                sum_reg <= '0; count_reg <= '0; sidx_reg <= '0;
                summing_reg <= 1'b1;
            end else if (summing_reg) begin
                if (int_ring_reg[sidx_reg[INT_W-1:0]] != 32'd0) begin
                    sum_reg <= sum_reg + {3'd0, int_ring_reg[sidx_reg[INT_W-1:0]]};
                    count_reg <= count_reg + (INT_W+1)'(1);
                end
                if (sidx_reg == (INT_W+1)'(INTERVAL_DEPTH - 1)) summing_reg <= 1'b0;
                sidx_reg <= sidx_reg + (INT_W+1)'(1);
            end
            if (cmd.rate && !cmd.div_start) begin
                if (count_reg == '0 || quotient < 35'(BPM_LOW)
                    || quotient > 35'(BPM_HIGH)) begin
                    valid_reg <= 1'b0;
                end else begin
                    valid_reg <= 1'b1;
                    rate_reg  <= quotient[7:0];
                end
            end
            if (cmd.emit) begin
                thr_out_reg   <= q8_int(thr_acc_reg);
                filt_out_reg  <= prev_reg;
                peak_out_reg  <= peak_reg;
                rate_out_reg  <= rate_reg;
                valid_out_reg <= valid_reg;
            end
        end
    end

    assign finger           = finger_reg;
    assign filtered_value   = filt_out_reg;
    assign threshold_value  = thr_out_reg;
    assign peak_found       = peak_out_reg;
    assign beats_per_minute = rate_out_reg;
    assign rate_valid       = valid_out_reg;
endmodule
`default_nettype wire

FILE: src/phr_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phr_controller
// Sequencer for one sample: filter, scan, threshold, peak, rate, result.
// ----------------------------------------------------------------------------
module phr_controller import phr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire logic        finger,
    input  wire phr_status_t status,
    output phr_cmd_t         cmd
);
    phr_state_t state_reg, state_next;
    logic       out_reg, out_next;
    logic       div_second_reg, div_second_next;

    always_comb begin
        state_next = state_reg;
        out_next = out_reg && !m_ready;
        div_second_next = div_second_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EMA;
            ST_EMA:  state_next = finger ? ST_AVG : ST_OUT;
            ST_AVG:  state_next = ST_SCAN;
            ST_SCAN: if (status.scan_done) state_next = ST_THR;
            ST_THR:  state_next = ST_PEAK;
            ST_PEAK: state_next = status.peak_hit ? ST_SUM : ST_OUT;
            ST_SUM:  if (status.sum_done) begin
                state_next = ST_DIV;
                div_second_next = 1'b0;
            end
            ST_DIV:  if (status.div_done) state_next = ST_RATE;
            ST_RATE: begin
                if (!div_second_reg) begin
                    div_second_next = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:  if (!out_reg || m_ready) begin
                state_next = ST_IDLE;
                out_next = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: cmd.load = s_valid;
            ST_EMA:  cmd.ema = finger;
            ST_AVG:  cmd.avg = 1'b1;
            ST_SCAN: cmd.scan_start = 1'b0;
            ST_THR:  cmd.thr = 1'b1;
            ST_PEAK: begin
                cmd.peak = 1'b1;
                cmd.sum_start = status.peak_hit;
            end
            ST_SUM:  cmd.div_start = status.sum_done;
            ST_DIV:  cmd.div_start = 1'b0;
            ST_RATE: begin
                // The first pass gives the mean, the second turns it into a rate.
                cmd.rate = 1'b1;
                cmd.div_start = !div_second_reg;
            end
            ST_OUT:  cmd.emit = (!out_reg || m_ready);
            default: cmd = '0;
        endcase
        if (state_reg == ST_AVG) cmd.scan_start = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_reg <= 1'b0;
            div_second_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_reg <= out_next;
            div_second_reg <= div_second_next;
        end
    end

    assign m_valid = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EMA)) else $error("load without start");
`endif
endmodule
`default_nettype wire

FILE: src/ppg_heart_rate_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppg_heart_rate_detector_core
// PPG heart-rate detector: filtering, adaptive threshold, peak and rate.
// ----------------------------------------------------------------------------
// One sample is taken at a time and its result is held in an output register
// until m_ready takes it. A sample with the finger absent passes EMA and OUT
// only; with a finger present and no peak it also passes AVG, SCAN, THR and
// PEAK, where SCAN steps through the 16-entry window at one entry a cycle.
// An accepted peak adds SUM over the 8-entry interval ring and two passes of a
// one-bit-per-cycle divider, each followed by the RATE state, which form the
// mean interval and then the rate. The next sample is taken while the previous
// result still waits on m_ready; a second finished result waits until the
// first has been taken.
module ppg_heart_rate_detector_core import phr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [11:0]        s_adc_sample,
    input  wire logic [31:0]        s_timestamp_ms,
    input  wire logic               s_finger_present,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [12:0]      m_filtered_value,
    output logic signed [12:0]      m_threshold_value,
    output logic                    m_peak_found,
    output logic [7:0]              m_beats_per_minute,
    output logic                    m_rate_valid
);
    logic [8:0]  alpha_reg;
    logic [11:0] ambient_reg;
    logic [15:0] min_beat_reg;
    phr_cmd_t    cmd;
    phr_status_t status;
    logic        finger;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= 9'd26;
            ambient_reg <= '0;
            min_beat_reg <= 16'd300;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ALPHA:    alpha_reg <= cfg_data[8:0];
                REG_AMBIENT:  ambient_reg <= cfg_data[11:0];
                REG_MIN_BEAT: min_beat_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    phr_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .finger(finger), .status(status), .cmd(cmd)
    );

    phr_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .alpha_q8(alpha_reg), .ambient_baseline(ambient_reg),
        .min_beat_interval_ms(min_beat_reg),
        .adc_sample(s_adc_sample), .timestamp_ms(s_timestamp_ms),
        .finger_present(s_finger_present), .finger(finger),
        .filtered_value(m_filtered_value), .threshold_value(m_threshold_value),
        .peak_found(m_peak_found), .beats_per_minute(m_beats_per_minute),
        .rate_valid(m_rate_valid)
    );
endmodule
`default_nettype wire

FILE: sim/phr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phr_checker
// Watches the sample and result channels of the heart-rate detector, predicts
// every result from its own copy of the filter, threshold and rate state, and
// counts mismatches.
// ----------------------------------------------------------------------------
module phr_checker import phr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [11:0]        s_adc_sample,
    input  wire logic [31:0]        s_timestamp_ms,
    input  wire logic               s_finger_present,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [12:0] m_filtered_value,
    input  wire logic signed [12:0] m_threshold_value,
    input  wire logic               m_peak_found,
    input  wire logic [7:0]         m_beats_per_minute,
    input  wire logic               m_rate_valid,
    output int                      fail_count,
    output int                      pending_count
);

    typedef struct packed {
        logic signed [12:0] filtered;
        logic signed [12:0] threshold;
        logic               peak;
        logic [7:0]         bpm;
        logic               valid;
    } beat_result_t;

    beat_result_t expected_q[$];

    logic [8:0]  alpha;
    logic [11:0] ambient;
    logic [15:0] min_gap;

    longint      sample_ema;
    longint      thr_ema;
    longint      avg_taps[AVERAGE_TAPS];
    int          avg_pos;
    longint      window[WINDOW_LEN];
    int          win_pos;
    longint      prev_value;
    logic [31:0] last_peak;
    logic [31:0] gaps[INTERVAL_DEPTH];
    int          gap_pos;
    logic [7:0]  rate;
    logic        rate_ok;

    assign pending_count = expected_q.size();

    function automatic longint smooth(longint acc, longint x, logic [8:0] a_in);
        longint a;
        longint t;
        a = a_in;
        if (a < 1) a = 1;
        if (a > 256) a = 256;
        t = a * x * 256 + (256 - a) * acc;
        // Arithmetic shift gives the floor for negative sums as well.
        return t >>> 8;
    endfunction

    task automatic store_gap(logic [31:0] gap);
        longint sum;
        longint n;
        longint bpm;
        sum = 0;
        n = 0;
        gaps[gap_pos] = gap;
        gap_pos = (gap_pos + 1) % INTERVAL_DEPTH;
        for (int i = 0; i < INTERVAL_DEPTH; i++) begin
            if (gaps[i] != 0) begin
                sum += gaps[i];
                n++;
            end
        end
        if (n == 0) begin
            rate_ok = 1'b0;
        end else begin
            bpm = 60000 / (sum / n);
            if (bpm >= 40 && bpm <= 180) begin
                rate_ok = 1'b1;
                rate = bpm[7:0];
            end else begin
                rate_ok = 1'b0;
            end
        end
    endtask

    task automatic predict_sample(logic [11:0] adc, logic [31:0] ts, logic finger);
        beat_result_t r;
        longint sum;
        longint cur;
        longint mn;
        longint mx;
        longint nt;
        longint thr;
        logic [31:0] gap;
        r = '0;
        if (finger) begin
            sample_ema = smooth(sample_ema, longint'(adc) - longint'(ambient), alpha);
            avg_taps[avg_pos] = sample_ema / 256;
            avg_pos = (avg_pos + 1) % AVERAGE_TAPS;
            sum = 0;
            for (int i = 0; i < AVERAGE_TAPS; i++) sum += avg_taps[i];
            cur = sum / AVERAGE_TAPS;
            window[win_pos] = cur;
            win_pos = (win_pos + 1) % WINDOW_LEN;
            mn = window[0];
            mx = window[0];
            for (int i = 1; i < WINDOW_LEN; i++) begin
                if (window[i] < mn) mn = window[i];
                if (window[i] > mx) mx = window[i];
            end
            nt = (5 * mn + 3 * (mx - mn)) / 5;
            thr_ema = smooth(thr_ema, nt, alpha);
            thr = thr_ema / 256;
            if (prev_value > thr && cur < prev_value) begin
                gap = ts - last_peak;
                if (gap >= min_gap) begin
                    r.peak = 1'b1;
                    store_gap(gap);
                    last_peak = ts;
                end
            end
            prev_value = cur;
        end else begin
            thr = thr_ema / 256;
        end
        r.filtered = prev_value[12:0];
        r.threshold = thr[12:0];
        r.bpm = rate;
        r.valid = rate_ok;
        expected_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        beat_result_t e;
        if (!aresetn) begin
            alpha = 9'd26;
            ambient = '0;
            min_gap = 16'd300;
            sample_ema = 0;
            thr_ema = 0;
            avg_pos = 0;
            win_pos = 0;
            gap_pos = 0;
            prev_value = 0;
            last_peak = '0;
            rate = '0;
            rate_ok = 1'b0;
            foreach (avg_taps[i]) avg_taps[i] = 0;
            foreach (window[i]) window[i] = 0;
            foreach (gaps[i]) gaps[i] = '0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ALPHA:    alpha = cfg_data[8:0];
                    REG_AMBIENT:  ambient = cfg_data[11:0];
                    REG_MIN_BEAT: min_gap = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_sample(s_adc_sample, s_timestamp_ms, s_finger_present);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_filtered_value !== e.filtered) begin
                        $error("filtered_value exp %0d got %0d", e.filtered, m_filtered_value);
                        fail_count++;
                    end
                    if (m_threshold_value !== e.threshold) begin
                        $error("threshold_value exp %0d got %0d", e.threshold,
                               m_threshold_value);
                        fail_count++;
                    end
                    if (m_peak_found !== e.peak) begin
                        $error("peak_found exp %0d got %0d", e.peak, m_peak_found);
                        fail_count++;
                    end
                    if (m_beats_per_minute !== e.bpm) begin
                        $error("beats_per_minute exp %0d got %0d", e.bpm,
                               m_beats_per_minute);
                        fail_count++;
                    end
                    if (m_rate_valid !== e.valid) begin
                        $error("rate_valid exp %0d got %0d", e.valid, m_rate_valid);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives synthetic pulse waveforms, noise and register changes into the
// heart-rate detector; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    import phr_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [11:0]        s_adc_sample = '0;
    logic [31:0]        s_timestamp_ms = '0;
    logic               s_finger_present = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [12:0] m_filtered_value;
    logic signed [12:0] m_threshold_value;
    logic               m_peak_found;
    logic [7:0]         m_beats_per_minute;
    logic               m_rate_valid;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    longint             cycle_count = 0;
    logic [31:0]        clock_ms = '0;

    always #4 aclk = ~aclk;

    ppg_heart_rate_detector_core i_dut (.*);

    phr_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ppg_heart_rate_detector_core regression: fail");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        // A finger-absent beat still may be in flight; let it settle.
        repeat (120) @(negedge aclk);
    endtask

    // Entered at a falling edge; leaves at a falling edge after acceptance.
    task automatic send_sample(logic [11:0] adc, logic [31:0] ts, logic finger);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_adc_sample <= adc;
        s_timestamp_ms <= ts;
        s_finger_present <= finger;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // A pulse-like waveform with random period, amplitude and noise.
    task automatic send_pulse_train(int count);
        int period;
        int amp;
        int base;
        int v;
        int ph;
        period = $urandom_range(40, 3);
        amp = $urandom_range(1500, 50);
        base = $urandom_range(2000, 0);
        for (int i = 0; i < count; i++) begin
            ph = i % period;
            v = base + ((ph < period / 2) ? amp * ph : amp * (period - ph)) / period
                + $urandom_range(30) - 15;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            clock_ms += $urandom_range(60, 5);
            if ($urandom_range(99) < 3)
                send_sample(12'($urandom), clock_ms, 1'($urandom_range(1)));
            else
                send_sample(v[11:0], clock_ms, ($urandom_range(99) >= 5));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, finger absent, wrapping timestamps, zero gap.
        send_sample(12'hFFF, 32'hFFFF_FFF0, 1'b1);
        send_sample(12'h000, 32'hFFFF_FFF8, 1'b1);
        send_sample(12'hFFF, 32'h0000_0000, 1'b0);
        for (int i = 0; i < 10; i++) send_sample(12'hFFF, 32'h10 + i, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(12'h000, 32'h400 + i * 400, 1'b1);
        drain();
        write_reg(REG_MIN_BEAT, 16'd0);
        write_reg(REG_ALPHA, 16'd256);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 12'hFFF : 12'h000, 32'd500, 1'b1);
        drain();
        write_reg(REG_ALPHA, 16'd0);
        write_reg(REG_AMBIENT, 16'hFFF);
        send_sample(12'h000, 32'hAAAA_5555, 1'b1);
        send_sample(12'hFFF, 32'h5555_AAAA, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 36 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                drain();
                case ((phase * 4 + blk) % 4)
                    0: write_reg(REG_ALPHA, 16'(256));
                    1: write_reg(REG_ALPHA, 16'(1));
                    default: write_reg(REG_ALPHA, 16'($urandom_range(511)));
                endcase
                write_reg(REG_AMBIENT, (blk == 3) ? 16'hFFF : 16'($urandom_range(1500)));
                case (blk)
                    0: write_reg(REG_MIN_BEAT, 16'hFFFF);
                    1: write_reg(REG_MIN_BEAT, 16'd0);
                    default: write_reg(REG_MIN_BEAT, 16'($urandom_range(600)));
                endcase
                if (blk == 2 && $urandom_range(1)) clock_ms = 32'hFFFF_F000;
                send_pulse_train(150);
            end
        end
        drain();
        if (fail_count == 0) begin
            $display("ppg_heart_rate_detector_core regression: pass");
        end else begin
            $display("ppg_heart_rate_detector_core regression: fail");
        end
        $finish;
    end

endmodule
